FILE: rtl/core/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg: shared types and constants for the chunk reassembly tracker
// Item layouts, status codes, register map and reset values.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int MAX_CHUNKS_DEF = 8192;

  // seen-store tags; tag zero never matches a live slot
  localparam int EPOCH_W = 8;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1500;
  localparam logic [15:0] GAP_RESET     = 16'd50;

  localparam logic [2:0] ADDR_TIMEOUT = 3'd0;
  localparam logic [2:0] ADDR_GAP     = 3'd4;

  localparam logic [28:0] BYTE_MAX = 29'h1FFF_FFFF;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_BAD      = 3'd2;
  localparam logic [2:0] ST_LATE     = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_OVERCAP  = 3'd5;
  localparam logic [2:0] ST_COMPLETE = 3'd6;

  typedef struct packed {
    logic [31:0] frame_id;
    logic [15:0] chunk_index;
    logic [15:0] total_chunks;
    logic [15:0] payload_len;
    logic [31:0] now_ms;
  } chunk_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        store_enable;
    logic [2:0]  store_slot;
    logic [12:0] store_chunk;
    logic        frame_complete;
    logic [2:0]  complete_slot;
    logic [13:0] complete_chunks;
    logic [28:0] complete_bytes;
  } chunk_out_t;

  // seen-store commands from the sequencer
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } seen_ctl_t;

endpackage

FILE: rtl/core/crt_cfg_regs.sv
// ----------------------------------------------------------------------------
// crt_cfg_regs: configuration register file
// APB-style write/read of the timeout and restart gap registers.
// ----------------------------------------------------------------------------
module crt_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] stale_timeout_ms,
  output logic [15:0] restart_gap
);

  logic wr_en;
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_timeout_ms <= crt_pkg::TIMEOUT_RESET;
      restart_gap      <= crt_pkg::GAP_RESET;
    end else if (wr_en) begin
      if (paddr == crt_pkg::ADDR_TIMEOUT) stale_timeout_ms <= pwdata[15:0];
      if (paddr == crt_pkg::ADDR_GAP)     restart_gap      <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == crt_pkg::ADDR_TIMEOUT) prdata = {16'd0, stale_timeout_ms};
    if (paddr == crt_pkg::ADDR_GAP)     prdata = {16'd0, restart_gap};
  end

endmodule

FILE: rtl/core/crt_seen_mem.sv
// ----------------------------------------------------------------------------
// crt_seen_mem: chunk-seen tag store
// One epoch tag per slot and chunk position, registered read, with a
// clearing sweep after reset and on request for one slot's region.
// ----------------------------------------------------------------------------
module crt_seen_mem #(
  parameter int SW = 3,
  parameter int CW = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  crt_pkg::seen_ctl_t          ctl,
  input  logic [SW-1:0]               slot,
  input  logic [CW-1:0]               chunk,
  input  logic [crt_pkg::EPOCH_W-1:0] wdata,
  output logic [crt_pkg::EPOCH_W-1:0] rdata,
  output logic                        busy
);

  localparam int AW = SW + CW;

  logic [crt_pkg::EPOCH_W-1:0] mem [2**AW];
  logic [AW-1:0] sweep_addr;
  logic          sweep_full;
  logic          sweep_end;

  assign sweep_end = sweep_full ? (&sweep_addr) : (&sweep_addr[CW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      sweep_full <= 1'b1;
      sweep_addr <= '0;
    end else if (busy) begin
      if (sweep_end) busy <= 1'b0;
      sweep_addr <= sweep_addr + 1'b1;
    end else if (ctl.clr) begin
      busy       <= 1'b1;
      sweep_full <= 1'b0;
      sweep_addr <= {slot, {CW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep_addr] <= '0;
    end else if (ctl.wr) begin
      mem[{slot, chunk}] <= wdata;
    end
    if (ctl.rd) rdata <= mem[{slot, chunk}];
  end

endmodule

FILE: rtl/core/chunk_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// chunk_reassembly_tracker: frame chunk bookkeeping
// Checks chunk headers, manages reassembly slots and gives payload write
// addresses and completion reports.
// ----------------------------------------------------------------------------
// One chunk header is handled at a time. A header with bad fields or an
// oversized count goes straight to the result state; otherwise the sequencer
// walks the slot table once (one age/id compare per cycle), decides
// late/restart/hit/allocate in the decide state, reads the seen store there
// and updates the slot in the update state, after a clearing wait when the
// slot's epoch wraps, and on completion walks the table again to release
// this frame and older ones. The seen store keeps an epoch tag per entry
// instead of clearing on allocation. After reset it runs a clearing pass over
// the whole store before the first item is taken, and each time a slot's
// epoch wraps (every 255 allocations of that slot) it clears that slot's
// region. Registers are to be written through the APB port only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module chunk_reassembly_tracker #(
  parameter int SLOT_COUNT = crt_pkg::SLOT_COUNT_DEF,
  parameter int MAX_CHUNKS = crt_pkg::MAX_CHUNKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  crt_pkg::chunk_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output crt_pkg::chunk_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int TW    = $clog2(MAX_CHUNKS + 1);
  localparam int EW    = crt_pkg::EPOCH_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_CLR_WAIT, S_UPDATE, S_FREE, S_DONE
  } state_t;

  logic [15:0] stale_timeout_ms;
  logic [15:0] restart_gap;

  crt_cfg_regs u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .stale_timeout_ms, .restart_gap
  );

  // slot table
  logic          slot_valid      [SLOT_COUNT];
  logic [31:0]   slot_frame_id   [SLOT_COUNT];
  logic [TW-1:0] slot_chunk_total[SLOT_COUNT];
  logic [TW-1:0] slot_chunk_count[SLOT_COUNT];
  logic [31:0]   slot_created_ms [SLOT_COUNT];
  logic [28:0]   slot_byte_total [SLOT_COUNT];
  logic [EW-1:0] slot_epoch      [SLOT_COUNT];
  logic [31:0]   last_done_id;

  state_t              state;
  crt_pkg::chunk_in_t  item;
  crt_pkg::chunk_out_t res;
  logic [SW-1:0]       scan;
  logic                hit;
  logic [SW-1:0]       hit_slot;
  logic                free_found;
  logic [SW-1:0]       free_idx;
  logic [SW-1:0]       low_slot;
  logic [31:0]         low_id;
  logic [SW-1:0]       cur;
  logic                alloc;

  crt_pkg::seen_ctl_t  seen_ctl;
  logic [SW-1:0]       seen_slot;
  logic [EW-1:0]       seen_rdata;
  logic                seen_busy;

  crt_seen_mem #(.SW(SW), .CW(CW)) u_seen (
    .clk, .rst,
    .ctl   (seen_ctl),
    .slot  (seen_slot),
    .chunk (item.chunk_index[CW-1:0]),
    .wdata (slot_epoch[cur]),
    .rdata (seen_rdata),
    .busy  (seen_busy)
  );

  // shared per-slot compare unit for the walk states
  logic [31:0] age;
  logic        aged;
  logic        live;
  logic        id_eq;
  logic        id_lt_low;
  logic        id_le_fid;
  assign age       = item.now_ms - slot_created_ms[scan];
  assign aged      = slot_valid[scan] && (age > {16'd0, stale_timeout_ms});
  assign live      = slot_valid[scan] && !aged;
  assign id_eq     = slot_frame_id[scan] == item.frame_id;
  assign id_lt_low = slot_frame_id[scan] < low_id;
  assign id_le_fid = slot_frame_id[scan] <= item.frame_id;

  // decide-step signals
  logic        is_late;
  logic        restart;
  logic [SW-1:0] pick;
  assign is_late = (last_done_id != 32'd0) && (item.frame_id <= last_done_id);
  assign restart = (last_done_id - item.frame_id) > {16'd0, restart_gap};
  assign pick    = free_found ? free_idx : low_slot;

  // update-step signals
  logic        seen;
  logic [29:0] byte_sum;
  logic [28:0] byte_new;
  logic [TW-1:0] count_new;
  assign seen      = !alloc && (seen_rdata == slot_epoch[cur]);
  assign byte_sum  = 30'(slot_byte_total[cur]) + 30'(item.payload_len);
  assign byte_new  = byte_sum[29] ? crt_pkg::BYTE_MAX : byte_sum[28:0];
  assign count_new = slot_chunk_count[cur] + 1'b1;

  logic [SW-1:0] dec_slot;
  assign dec_slot = (is_late && restart) ? '0 : (hit ? hit_slot : pick);

  always_comb begin
    seen_ctl  = '0;
    seen_slot = cur;
    if (state == S_DECIDE) begin
      seen_slot = dec_slot;
      seen_ctl.rd = 1'b1;
      seen_ctl.clr = !(is_late && !restart) && !(hit && !(is_late && restart))
                     && (slot_epoch[dec_slot] == {EW{1'b1}});
    end
    if (state == S_UPDATE) seen_ctl.wr = !seen;
  end

  assign in_stall = (state != S_IDLE) || seen_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      res          <= '0;
      last_done_id <= 32'd0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        slot_valid[s] <= 1'b0;
        slot_epoch[s] <= EW'(1);
      end
    end else begin
      // S_DONE drives out_valid itself
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item       <= in_data;
            scan       <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            if (in_data.total_chunks == 16'd0 || in_data.payload_len == 16'd0 ||
                in_data.chunk_index >= in_data.total_chunks) begin
              res.status <= crt_pkg::ST_BAD;
              state      <= S_DONE;
            end else if (17'(in_data.total_chunks) > 17'(MAX_CHUNKS)) begin
              res.status <= crt_pkg::ST_OVERCAP;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // age out, look for the frame, first free slot and lowest id
          if (aged) slot_valid[scan] <= 1'b0;
          if (live && id_eq && !hit) begin
            hit      <= 1'b1;
            hit_slot <= scan;
          end
          if (!live && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= scan;
          end
          if (scan == '0 || id_lt_low) begin
            low_slot <= scan;
            low_id   <= slot_frame_id[scan];
          end
          scan <= scan + 1'b1;
          if (scan == LAST_SLOT) state <= S_DECIDE;
        end
        S_DECIDE: begin
          cur <= dec_slot;
          if (is_late && !restart) begin
            res.status <= crt_pkg::ST_LATE;
            state      <= S_DONE;
          end else if (hit && !(is_late && restart)) begin
            alloc <= 1'b0;
            if (slot_chunk_total[hit_slot] != TW'(item.total_chunks)) begin
              res.status <= crt_pkg::ST_MISMATCH;
              state      <= S_DONE;
            end else begin
              state <= S_UPDATE;
            end
          end else begin
            if (is_late && restart) begin
              last_done_id <= 32'd0;
              for (int s = 0; s < SLOT_COUNT; s++)
                if (SW'(s) != dec_slot) slot_valid[s] <= 1'b0;
            end
            alloc                      <= 1'b1;
            slot_valid[dec_slot]       <= 1'b1;
            slot_frame_id[dec_slot]    <= item.frame_id;
            slot_chunk_total[dec_slot] <= TW'(item.total_chunks);
            slot_chunk_count[dec_slot] <= '0;
            slot_created_ms[dec_slot]  <= item.now_ms;
            slot_byte_total[dec_slot]  <= '0;
            if (slot_epoch[dec_slot] == {EW{1'b1}}) begin
              slot_epoch[dec_slot] <= EW'(1);
              state                <= S_CLR_WAIT;
            end else begin
              slot_epoch[dec_slot] <= slot_epoch[dec_slot] + 1'b1;
              state                <= S_UPDATE;
            end
          end
        end
        S_CLR_WAIT: begin
          if (!seen_busy) state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (seen) begin
            res.status <= crt_pkg::ST_DUP;
            state      <= S_DONE;
          end else begin
            slot_chunk_count[cur] <= count_new;
            slot_byte_total[cur]  <= byte_new;
            res.store_enable      <= 1'b1;
            res.store_slot        <= 3'(cur);
            res.store_chunk       <= item.chunk_index[12:0];
            if (count_new == slot_chunk_total[cur]) begin
              res.status          <= crt_pkg::ST_COMPLETE;
              res.frame_complete  <= 1'b1;
              res.complete_slot   <= 3'(cur);
              res.complete_chunks <= 14'(slot_chunk_total[cur]);
              res.complete_bytes  <= byte_new;
              last_done_id        <= item.frame_id;
              scan                <= '0;
              state               <= S_FREE;
            end else begin
              res.status <= crt_pkg::ST_STORED;
              state      <= S_DONE;
            end
          end
        end
        S_FREE: begin
          // release this frame and all older ones
          if (slot_valid[scan] && id_le_fid) slot_valid[scan] <= 1'b0;
          scan <= scan + 1'b1;
          if (scan == LAST_SLOT) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            res       <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sim/chunk_reassembly_tracker_tb.sv
// ----------------------------------------------------------------------------
// chunk_reassembly_tracker_tb: self-checking bench for the reassembly tracker
// Drives chunk headers through the valid/stall port and compares each result
// with a behavioral predictor. Registers are set over APB between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Predicts tracker results and checks the ones the block produces.
class reassembly_scoreboard;
  logic [15:0] timeout_ms;
  logic [15:0] gap;
  bit          valid_q [8];
  logic [31:0] fid_q   [8];
  logic [13:0] tot_q   [8];
  logic [13:0] cnt_q   [8];
  logic [31:0] born_q  [8];
  logic [28:0] bytes_q [8];
  bit          seen    [8][8192];
  logic [31:0] last_done;
  crt_pkg::chunk_out_t pending[$];
  int          mismatches;
  int          checked;
  int          completions;

  function new();
    timeout_ms  = crt_pkg::TIMEOUT_RESET;
    gap         = crt_pkg::GAP_RESET;
    last_done   = '0;
    mismatches  = 0;
    checked     = 0;
    completions = 0;
    for (int s = 0; s < 8; s++) free_slot(s);
  endfunction

  function void free_slot(int s);
    valid_q[s] = 0;
    fid_q[s]   = '0;
    tot_q[s]   = '0;
    cnt_q[s]   = '0;
    born_q[s]  = '0;
    bytes_q[s] = '0;
  endfunction

  // Work out the result for one accepted header and queue it.
  function void note_chunk(crt_pkg::chunk_in_t c);
    crt_pkg::chunk_out_t r;
    int slot;
    int low;
    logic [31:0] age;
    logic [29:0] sum;
    r = '0;
    slot = -1;
    if (c.total_chunks == 0 || c.payload_len == 0 || c.chunk_index >= c.total_chunks) begin
      r.status = crt_pkg::ST_BAD;
    end else if (c.total_chunks > 8192) begin
      r.status = crt_pkg::ST_OVERCAP;
    end else begin
      for (int s = 0; s < 8; s++) begin
        age = c.now_ms - born_q[s];
        if (valid_q[s] && age > {16'd0, timeout_ms}) free_slot(s);
      end
      r.status = crt_pkg::ST_STORED;
      if (last_done != 0 && c.frame_id <= last_done) begin
        if (last_done - c.frame_id > {16'd0, gap}) begin
          last_done = '0;
          for (int s = 0; s < 8; s++) free_slot(s);
        end else begin
          r.status = crt_pkg::ST_LATE;
        end
      end
      if (r.status == crt_pkg::ST_STORED) begin
        for (int s = 0; s < 8; s++)
          if (slot < 0 && valid_q[s] && fid_q[s] == c.frame_id) slot = s;
        if (slot < 0) begin
          for (int s = 0; s < 8; s++)
            if (slot < 0 && !valid_q[s]) slot = s;
          if (slot < 0) begin
            low = 0;
            for (int s = 1; s < 8; s++)
              if (fid_q[s] < fid_q[low]) low = s;
            slot = low;
          end
          free_slot(slot);
          valid_q[slot] = 1;
          fid_q[slot]   = c.frame_id;
          tot_q[slot]   = c.total_chunks[13:0];
          born_q[slot]  = c.now_ms;
          for (int k = 0; k < 8192; k++) seen[slot][k] = 0;
        end else if ({2'b0, tot_q[slot]} != c.total_chunks) begin
          r.status = crt_pkg::ST_MISMATCH;
        end
      end
      if (r.status == crt_pkg::ST_STORED && seen[slot][c.chunk_index[12:0]])
        r.status = crt_pkg::ST_DUP;
      if (r.status == crt_pkg::ST_STORED) begin
        seen[slot][c.chunk_index[12:0]] = 1;
        cnt_q[slot]++;
        sum = bytes_q[slot] + c.payload_len;
        bytes_q[slot] = sum[29] ? crt_pkg::BYTE_MAX : sum[28:0];
        r.store_enable = 1;
        r.store_slot   = slot[2:0];
        r.store_chunk  = c.chunk_index[12:0];
        if (cnt_q[slot] == tot_q[slot]) begin
          r.status          = crt_pkg::ST_COMPLETE;
          r.frame_complete  = 1;
          r.complete_slot   = slot[2:0];
          r.complete_chunks = tot_q[slot];
          r.complete_bytes  = bytes_q[slot];
          last_done = c.frame_id;
          completions++;
          for (int s = 0; s < 8; s++)
            if (valid_q[s] && fid_q[s] <= c.frame_id) free_slot(s);
        end
      end
    end
    pending = {pending, r};
  endfunction

  function void check_result(crt_pkg::chunk_out_t got);
    crt_pkg::chunk_out_t exp;
    bit bad;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp = pending.pop_front();
    bad = exp.status != got.status || exp.store_enable != got.store_enable ||
          exp.store_slot != got.store_slot || exp.store_chunk != got.store_chunk ||
          exp.frame_complete != got.frame_complete ||
          exp.complete_slot != got.complete_slot ||
          exp.complete_chunks != got.complete_chunks ||
          exp.complete_bytes != got.complete_bytes;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp st=%0d en=%0d ss=%0d sc=%0d fc=%0d cs=%0d cc=%0d cb=%0d",
                 exp.status, exp.store_enable, exp.store_slot, exp.store_chunk,
                 exp.frame_complete, exp.complete_slot, exp.complete_chunks,
                 exp.complete_bytes);
      if (bad && mismatches <= 10)
        $display("          got st=%0d en=%0d ss=%0d sc=%0d fc=%0d cs=%0d cc=%0d cb=%0d",
                 got.status, got.store_enable, got.store_slot, got.store_chunk,
                 got.frame_complete, got.complete_slot, got.complete_chunks,
                 got.complete_bytes);
    end
  endfunction
endclass

module chunk_reassembly_tracker_tb;
  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  crt_pkg::chunk_in_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  crt_pkg::chunk_out_t out_data;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // idle odds in percent for each side, changed per phase
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned idle_count = 0;
  int unsigned sent = 0;
  // a completing chunk scans twice, plus a possible epoch clear of a slot
  localparam int unsigned IDLE_LIMIT = 200000;
  // base frame id and clock for well-formed sequences
  logic [31:0] frame_base = 32'd100;
  logic [31:0] clock_ms   = 32'd10;

  reassembly_scoreboard sb = new();

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  chunk_reassembly_tracker DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Result side: check on each accepted result, stall at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Watchdog: cycles with no handshake on either side. Covers the
  // clearing pass after reset.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count > IDLE_LIMIT) begin
      $display("timeout: no progress, %0d results still expected", sb.pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one header and hold it until accepted.
  task automatic send_chunk(crt_pkg::chunk_in_t c);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_valid <= 1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_chunk(c);
    sent++;
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_fields(logic [31:0] fid, logic [15:0] idx, logic [15:0] tot,
                             logic [15:0] len, logic [31:0] now);
    crt_pkg::chunk_in_t c;
    c.frame_id = fid; c.chunk_index = idx; c.total_chunks = tot;
    c.payload_len = len; c.now_ms = now;
    send_chunk(c);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= value; penable <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == crt_pkg::ADDR_TIMEOUT) sb.timeout_ms = value[15:0];
    else sb.gap = value[15:0];
    @(posedge clk);
  endtask

  // Wait for every expected result, then let the block settle.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // One frame sent in shuffled order with occasional duplicates and noise.
  task automatic send_frame();
    int unsigned n;
    int unsigned order[$];
    int unsigned k;
    logic [31:0] fid;
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
    case ($urandom_range(9))
      0: fid = frame_base - $urandom_range(120);
      1: fid = $urandom;
      default: fid = frame_base + $urandom_range(3);
    endcase
    frame_base = fid + 1;
    for (int i = 0; i < n; i++) order = {order, i};
    order.shuffle();
    for (int i = 0; i < n; i++) begin
      clock_ms = clock_ms + $urandom_range(40);
      k = order[i];
      send_fields(fid, k[15:0], n[15:0], 16'($urandom_range(1500, 1)), clock_ms);
      case ($urandom_range(15))
        0: send_fields(fid, k[15:0], n[15:0], 16'($urandom_range(65535, 1)), clock_ms);
        1: send_fields(fid, k[15:0], n[15:0] + 16'd1, 16'd9, clock_ms);
        2: send_fields($urandom, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
        3: send_fields(frame_base + $urandom_range(5), 16'd0, 16'd3, 16'd4, clock_ms);
        default: ;
      endcase
    end
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned goal;
    goal = sent + items;
    while (sent < goal) send_frame();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: field extremes, every status, time wrap
    send_fields(32'd5, 16'd0, 16'd0, 16'd1, 32'd0);            // zero count
    send_fields(32'd5, 16'd0, 16'd1, 16'd0, 32'd0);            // zero length
    send_fields(32'd5, 16'd3, 16'd3, 16'd1, 32'd0);            // index past count
    send_fields(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_fields(32'd5, 16'd0, 16'd8193, 16'd1, 32'd0);         // over capacity
    send_fields(32'd5, 16'd0, 16'd2, 16'hFFFF, 32'hFFFF_FFF0);
    send_fields(32'd5, 16'd0, 16'd2, 16'd7, 32'hFFFF_FFF8);    // duplicate
    send_fields(32'd5, 16'd1, 16'd3, 16'd7, 32'd4);            // count mismatch
    send_fields(32'd5, 16'd1, 16'd2, 16'hFFFF, 32'd6);         // complete across wrap
    send_fields(32'd4, 16'd0, 16'd1, 16'd1, 32'd7);            // late
    send_fields(32'd0, 16'd0, 16'd1, 16'd1, 32'd8);            // late, lag too small to restart
    send_fields(32'd0, 16'd0, 16'd1, 16'd1, 32'd9);            // frame zero again
    for (int i = 0; i < 9; i++)                                // fill and evict
      send_fields(32'd200 - i, 16'd0, 16'd2, 16'd3, 32'd10);
    send_fields(32'd300, 16'd0, 16'd1, 16'd1, 32'd5000);       // ages all out
    send_fields(32'd400, 16'd8191, 16'd8192, 16'd1, 32'd5001); // top position
    drain();

    // register extremes with a short burst each
    write_reg(crt_pkg::ADDR_TIMEOUT, 32'd0);
    write_reg(crt_pkg::ADDR_GAP, 32'd0);
    send_fields(32'd500, 16'd0, 16'd2, 16'd1, 32'd6000);
    send_fields(32'd500, 16'd1, 16'd2, 16'd1, 32'd6000);
    send_fields(32'd499, 16'd0, 16'd1, 16'd1, 32'd6000);       // lag 1 restarts
    drain();
    write_reg(crt_pkg::ADDR_TIMEOUT, 32'd65535);
    write_reg(crt_pkg::ADDR_GAP, 32'd65535);
    // full-length payloads
    for (int i = 0; i < 4; i++)
      send_fields(32'd9000, 16'(i), 16'd4, 16'hFFFF, 32'd6001);
    drain();

    frame_base = 32'd1000;
    write_reg(crt_pkg::ADDR_TIMEOUT, 32'd1500);
    write_reg(crt_pkg::ADDR_GAP, 32'd50);
    send_idle = 32; recv_idle = 58;
    random_phase(550);
    drain();

    write_reg(crt_pkg::ADDR_TIMEOUT, 32'd200);
    write_reg(crt_pkg::ADDR_GAP, 32'd10);
    send_idle = 58; recv_idle = 32;
    random_phase(550);
    drain();

    write_reg(crt_pkg::ADDR_TIMEOUT, 32'd3000);
    write_reg(crt_pkg::ADDR_GAP, 32'd100);
    send_idle = 0; recv_idle = 0;
    random_phase(500);
    drain();

    $display("covered %0d chunk headers, %0d results checked, %0d frames completed",
             sent, sb.checked, sb.completions);
    $display("register settings from zero to full scale, three idle patterns");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/crt_pkg.sv
rtl/core/crt_cfg_regs.sv
rtl/core/crt_seen_mem.sv
rtl/core/chunk_reassembly_tracker.sv
sim/chunk_reassembly_tracker_tb.sv
